FILE: hdl/trial_division_prime_test_defines.svh
// Assertion macros for the trial division prime test block.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property while out of reset.
`define TDPT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tdpt assertion failed");
// Check a property at every edge, reset included.
`define TDPT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tdpt assertion failed");
`else
`define TDPT_ASSERT(label, clk, rst_n, prop)
`define TDPT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: hdl/tdpt_pkg.sv
// Shared widths, microcode formats and control store for the prime test block.
package tdpt_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int SQ_W        = VALUE_WIDTH + 1;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int STEP_W      = 3;

  localparam logic [1:0] CNT_ZERO      = 2'd0;
  localparam logic [1:0] CNT_ONE       = 2'd1;
  localparam logic [1:0] CNT_PRIME     = 2'd2;
  localparam logic [1:0] CNT_SATURATED = 2'd3;

  typedef enum logic [STEP_W-1:0] {
    STEP_IDLE  = 3'd0,
    STEP_CHECK = 3'd1,
    STEP_DIV   = 3'd2,
    STEP_TEST  = 3'd3,
    STEP_NEXT  = 3'd4,
    STEP_HIT   = 3'd6,
    STEP_DONE  = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_LOAD    = 3'd1,
    OP_SETUP   = 3'd2,
    OP_DIV     = 3'd3,
    OP_ADVANCE = 3'd4,
    OP_SAT     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    CND_NEXT       = 3'd0,
    CND_ALWAYS     = 3'd1,
    CND_NO_INPUT   = 3'd2,
    CND_BOUND_DONE = 3'd3,
    CND_BITS_LEFT  = 3'd4,
    CND_REM_ZERO   = 3'd5,
    CND_OUT_BUSY   = 3'd6
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  accept;
    logic  emit;
  } uword_t;

  typedef struct packed {
    logic bound_done;
    logic bits_left;
    logic rem_zero;
    logic is_prime;
  } dp_status_t;

  // Control store: jump to target when cond holds, else advance one step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{op: OP_NOP, cond: CND_ALWAYS, target: STEP_IDLE, accept: 1'b0, emit: 1'b0};
    case (s)
      STEP_IDLE:  w = '{op: OP_LOAD,    cond: CND_NO_INPUT,   target: STEP_IDLE,
                        accept: 1'b1, emit: 1'b0};
      STEP_CHECK: w = '{op: OP_SETUP,   cond: CND_BOUND_DONE, target: STEP_DONE,
                        accept: 1'b0, emit: 1'b0};
      STEP_DIV:   w = '{op: OP_DIV,     cond: CND_BITS_LEFT,  target: STEP_DIV,
                        accept: 1'b0, emit: 1'b0};
      STEP_TEST:  w = '{op: OP_NOP,     cond: CND_REM_ZERO,   target: STEP_HIT,
                        accept: 1'b0, emit: 1'b0};
      STEP_NEXT:  w = '{op: OP_ADVANCE, cond: CND_ALWAYS,     target: STEP_CHECK,
                        accept: 1'b0, emit: 1'b0};
      STEP_HIT:   w = '{op: OP_SAT,     cond: CND_NEXT,       target: STEP_DONE,
                        accept: 1'b0, emit: 1'b0};
      STEP_DONE:  w = '{op: OP_NOP,     cond: CND_OUT_BUSY,   target: STEP_DONE,
                        accept: 1'b0, emit: 1'b1};
      default:    w = '{op: OP_NOP,     cond: CND_ALWAYS,     target: STEP_IDLE,
                        accept: 1'b0, emit: 1'b0};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/trial_division_prime_test.sv
// Sequence: accept a number on the idle step, then for each candidate divisor from 2 up: a bound
// check, a bit-serial division and a remainder test, then an advance; a hit or the bound ends
// the search and the verdict is emitted; below four no candidate is tried. Throughput: one number at a time.
// The bit-serial remainder unit (one quotient bit per cycle) sets the per-candidate cost.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle and empties the
// result register; no clearing pass is needed.
module trial_division_prime_test (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tdpt_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_is_prime
);
  import tdpt_pkg::*;
  `include "trial_division_prime_test_defines.svh"

  uword_t     uword;
  dp_status_t status;
  logic       out_busy;
  logic       emit_fire;
  logic       out_valid_r, out_valid_nxt;
  logic       out_is_prime_r;

  // Result register holds a finished verdict until the sink takes the transfer.
  assign out_busy  = out_valid_r && !out_ready;
  // Drop the verdict into the result register once it is free; otherwise the
  // sequencer parks on its final step.
  assign emit_fire = uword.emit && !out_busy;

  // Take a new number only on the idle step of the program.
  assign in_ready = uword.accept;

  tdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .status   (status),
    .uword    (uword)
  );

  tdpt_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_value),
    .op       (uword.op),
    .status   (status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the verdict: prime exactly when two divisors were counted.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_is_prime_r <= status.is_prime;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // An accepted number always leaves the idle step at once.
  `TDPT_ASSERT(a_accept_leaves_idle, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  // A new result only appears from the emitting step.
  `TDPT_ASSERT(a_result_from_emit, clk, rst_n, $rose(out_valid) |-> $past(uword.emit))
  // Reset empties the result register.
  `TDPT_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid)

endmodule

FILE: hdl/tdpt_ctrl.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
module tdpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_busy,
  input  tdpt_pkg::dp_status_t status,
  output tdpt_pkg::uword_t     uword
);
  import tdpt_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  logic  take_jump;

  assign uword = ucode(pc_r);

  always_comb begin
    case (uword.cond)
      CND_NEXT:       take_jump = 1'b0;
      CND_ALWAYS:     take_jump = 1'b1;
      CND_NO_INPUT:   take_jump = !in_valid;
      CND_BOUND_DONE: take_jump = status.bound_done;
      CND_BITS_LEFT:  take_jump = status.bits_left;
      CND_REM_ZERO:   take_jump = status.rem_zero;
      CND_OUT_BUSY:   take_jump = out_busy;
      default:        take_jump = 1'b1;
    endcase
  end

  // Last step wraps back to idle.
  assign pc_nxt = take_jump ? uword.target : step_t'(STEP_W'(pc_r + 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: hdl/tdpt_datapath.sv
// Datapath: candidate divisor, its square, bit-serial remainder unit, divisor count.
module tdpt_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [tdpt_pkg::VALUE_WIDTH-1:0]     in_value,
  input  tdpt_pkg::op_t                        op,
  output tdpt_pkg::dp_status_t                 status
);
  import tdpt_pkg::*;

  logic [VALUE_WIDTH-1:0] n_r,   n_nxt;
  logic [VALUE_WIDTH-1:0] d_r,   d_nxt;
  logic [SQ_W-1:0]        sq_r,  sq_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] q_r,   q_nxt;
  logic [BIT_CNT_W-1:0]   bit_r, bit_nxt;
  logic [1:0]             cnt_r, cnt_nxt;

  logic [VALUE_WIDTH:0]   partial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign partial = {rem_r, q_r[VALUE_WIDTH-1]};
  assign diff    = partial - {1'b0, d_r};
  assign fits    = partial >= {1'b0, d_r};

  always_comb begin
    n_nxt   = n_r;
    d_nxt   = d_r;
    sq_nxt  = sq_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    bit_nxt = bit_r;
    cnt_nxt = cnt_r;
    case (op)
      OP_LOAD: begin
        n_nxt  = in_value;
        d_nxt  = VALUE_WIDTH'(2);
        sq_nxt = SQ_W'(4);
        if (in_value == '0) begin
          cnt_nxt = CNT_ZERO;
        end else if (in_value == VALUE_WIDTH'(1)) begin
          cnt_nxt = CNT_ONE;
        end else begin
          cnt_nxt = CNT_PRIME;
        end
      end
      OP_SETUP: begin
        rem_nxt = '0;
        q_nxt   = n_r;
        bit_nxt = BIT_CNT_W'(VALUE_WIDTH - 1);
      end
      OP_DIV: begin
        rem_nxt = fits ? diff[VALUE_WIDTH-1:0] : partial[VALUE_WIDTH-1:0];
        q_nxt   = {q_r[VALUE_WIDTH-2:0], fits};
        bit_nxt = bit_r - 1'b1;
      end
      OP_ADVANCE: begin
        d_nxt  = d_r + 1'b1;
        sq_nxt = sq_r + {d_r, 1'b1};
      end
      OP_SAT: begin
        cnt_nxt = CNT_SATURATED;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r   <= '0;
      rem_r <= '0;
      cnt_r <= CNT_ZERO;
      bit_r <= '0;
    end else begin
      d_r   <= d_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r  <= n_nxt;
    sq_r <= sq_nxt;
    q_r  <= q_nxt;
  end

  assign status.bound_done = (SQ_W'(n_r) < SQ_W'(4)) || (sq_r > SQ_W'(n_r));
  assign status.bits_left  = bit_r != '0;
  assign status.rem_zero   = rem_r == '0;
  assign status.is_prime   = cnt_r == CNT_PRIME;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the trial division prime test block.
`timescale 1ns / 100ps

module tb_top;
  import tdpt_pkg::*;

  // Run limits. The slowest number is a prime above 255*255.
  // Allow about 100 of those, plus receiver stalls and the long hold-off, several times over.
  localparam int unsigned CYCLE_LIMIT    = 3_000_000;
  localparam int          RX_HOLD_CYCLES = 600;
  localparam int          SETTLE_CYCLES  = 100;

  typedef struct {
    logic [VALUE_WIDTH-1:0] number;
    logic                   is_prime;
  } verdict_t;

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic [VALUE_WIDTH-1:0] in_value     = '0;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic                   out_is_prime;

  // Expected verdicts, oldest first.
  verdict_t    pending_verdicts[$];

  // Our own copy of the search state after the last number.
  logic [VALUE_WIDTH-1:0] search_divisor   = '0;
  logic [VALUE_WIDTH-1:0] search_remainder = '0;
  logic [1:0]             search_count     = CNT_ZERO;

  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int          hold_asked   = 0;
  int          hold_taken   = 0;
  int          hold_left    = 0;
  int unsigned cycle_count  = 0;
  int          error_count  = 0;
  int          numbers_sent = 0;
  int          verdicts_seen = 0;
  int          primes_seen  = 0;

  trial_division_prime_test uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_prime (out_is_prime)
  );

  always #5 clk = ~clk;

  // Count divisors among 1..n, saturating at three. Only candidates up to sqrt(n)
  // need a remainder: 1 and n always divide, and any other divisor has a small partner.
  function automatic logic predict_prime(logic [VALUE_WIDTH-1:0] n);
    int unsigned num;
    int unsigned cand;
    int unsigned last_cand;
    int unsigned last_rem;
    logic [1:0]  divisors;
    num       = n;
    divisors  = CNT_ZERO;
    last_cand = 0;
    last_rem  = 0;
    if (num >= 1) begin
      divisors  = CNT_ONE;
      last_cand = 1;
    end
    if (num >= 2) begin
      divisors  = CNT_PRIME;
      last_cand = num;
    end
    for (cand = 2; num >= 4 && cand * cand <= num; cand++) begin
      last_cand = cand;
      last_rem  = num % cand;
      if (last_rem == 0) begin
        divisors = CNT_SATURATED;
        break;
      end
    end
    search_divisor   = last_cand[VALUE_WIDTH-1:0];
    search_remainder = last_rem[VALUE_WIDTH-1:0];
    search_count     = divisors;
    return (divisors == CNT_PRIME);
  endfunction

  // Offer one number, optionally after an idle gap, and hold it until the transfer.
  // Valid is left high afterwards; the caller either sends again or drops it.
  task automatic send_number(input logic [VALUE_WIDTH-1:0] n);
    int       gap;
    verdict_t v;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v.number   = n;
    v.is_prime = predict_prime(n);
    pending_verdicts.push_back(v);
    numbers_sent++;
  endtask

  // Drop valid and hold until every expected verdict has come back.
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Edges of the range and the special cases: zero, one, two, first composite,
  // squares (for a prime root the hit lands on the last candidate), the largest 16-bit prime,
  // and alternating bit patterns.
  task automatic run_directed_values();
    logic [VALUE_WIDTH-1:0] picks[$];
    picks = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd8, 16'd9, 16'd15,
              16'd25, 16'd49, 16'd97, 16'd127, 16'd128, 16'd256, 16'd32749, 16'd32768,
              16'd63001, 16'd65025, 16'd65521, 16'd65534, 16'd65535, 16'hAAAA, 16'h5555};
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    foreach (picks[i]) send_number(picks[i]);
    drain_verdicts();
  endtask

  // Hold the receiver off for a long stretch while numbers keep coming, so the
  // result register fills and the block stops taking input.
  task automatic run_output_hold();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_asked++;
    repeat (6) send_number(16'($urandom_range(50, 400)));
    drain_verdicts();
  endtask

  // Pause the sender until the block is empty, then resume.
  task automatic run_drain_pause();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    repeat (4) send_number(16'($urandom_range(0, 2000)));
    drain_verdicts();
    repeat (4) send_number(16'($urandom_range(0, 2000)));
    drain_verdicts();
  endtask

  // Random numbers: mostly small ones to keep the run short, some over the full
  // range, some perfect squares and some odd values (more likely prime, so slow).
  task automatic run_random_numbers(input int count, input int tx_pct, input int rx_pct);
    logic [VALUE_WIDTH-1:0] n;
    int                     root;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: n = 16'($urandom_range(0, 1023));
        5, 6, 7:       n = 16'($urandom());
        8: begin
          root = $urandom_range(2, 255);
          n    = 16'(root * root);
        end
        default:       n = 16'($urandom()) | 16'd1;
      endcase
      send_number(n);
    end
    drain_verdicts();
  endtask

  // Receiver: random stalls, or a counted hold-off when asked for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = RX_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expected verdict.
  always @(posedge clk) begin : verdict_check
    verdict_t head;
    if (rst_n && out_valid && out_ready) begin
      verdicts_seen++;
      if (out_is_prime) primes_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("out_is_prime: unexpected result %0b with nothing pending", out_is_prime);
        error_count++;
      end else begin
        head = pending_verdicts.pop_front();
        if (out_is_prime !== head.is_prime) begin
          $error("out_is_prime for %0d: expected %0b, actual %0b",
                 head.number, head.is_prime, out_is_prime);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d verdicts pending", cycle_count,
               pending_verdicts.size());
      $display("FAIL trial_division_prime_test");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed_values();
    run_output_hold();
    run_drain_pause();
    run_random_numbers(20, 22, 49);
    run_random_numbers(20, 49, 22);
    run_random_numbers(20, 0, 0);

    // Hold a little longer to catch any stray result.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d expected verdicts never arrived", pending_verdicts.size());
      error_count++;
    end

    $display("Sent %0d numbers, checked %0d verdicts (%0d prime) in %0d cycles",
             numbers_sent, verdicts_seen, primes_seen, cycle_count);
    $display("Covered range edges, zero and one, prime squares, output hold-off and drains");
    if (error_count == 0) begin
      $display("PASS trial_division_prime_test");
    end else begin
      $display("FAIL trial_division_prime_test");
    end
    $finish;
  end

endmodule
